// ===== rtl/core/stpf_pkg.sv =====
package stpf_pkg;

	localparam int WINDOW_DEPTH  = 20;
	localparam int MATCH_AT      = WINDOW_DEPTH - 13;
	localparam int TAIL_LEN      = 5;
	localparam int POS_SAT       = 31;
	localparam int STAMP_MIN_POS = 19;
	localparam int HOUR_LIM      = 24;
	localparam int DAY_MAX       = 31;
	localparam int YEAR_MIN      = 20;
	localparam int YEAR_MAX      = 51;
	localparam int YEAR_BIAS     = 20;
	localparam int RES_W         = 51;
	localparam int OUT_TDATA_W   = ((RES_W + 7) / 8) * 8;

	typedef logic [7:0] char_t;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_COLON = 8'h3A;
	localparam char_t CH_0     = 8'h30;
	localparam char_t CH_1     = 8'h31;
	localparam char_t CH_2     = 8'h32;
	localparam char_t CH_5     = 8'h35;
	localparam char_t CH_7     = 8'h37;
	localparam char_t CH_9     = 8'h39;
	localparam char_t CH_UP_A  = 8'h41;
	localparam char_t CH_UP_D  = 8'h44;
	localparam char_t CH_UP_F  = 8'h46;
	localparam char_t CH_UP_J  = 8'h4A;
	localparam char_t CH_UP_M  = 8'h4D;
	localparam char_t CH_UP_N  = 8'h4E;
	localparam char_t CH_UP_O  = 8'h4F;
	localparam char_t CH_UP_S  = 8'h53;
	localparam char_t CH_LO_A  = 8'h61;
	localparam char_t CH_LO_N  = 8'h6E;
	localparam char_t CH_LO_P  = 8'h70;
	localparam char_t CH_LO_R  = 8'h72;

	typedef enum logic [1:0] {
		PH_SCAN,
		PH_TAIL,
		PH_HELD
	} phase_t;

	typedef struct packed {
		char_t [WINDOW_DEPTH-1:0] win;
		logic                     matched;
		logic                     pos_ok;
	} snap_t;

	typedef struct packed {
		logic [15:0] fat_time;
		logic [15:0] fat_date;
		logic        stamp_valid;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic        clock_found;
	} result_t;

	function automatic logic in_range(char_t c, char_t lo, char_t hi);
		return (c >= lo) && (c <= hi);
	endfunction

	function automatic logic is_digit(char_t c);
		return in_range(c, CH_0, CH_9);
	endfunction

	function automatic logic [3:0] dig(char_t c);
		return 4'(c - CH_0);
	endfunction

	// tens * 10 + ones as shift-add
	function automatic logic [6:0] two_dig(char_t a, char_t b);
		logic [3:0] t;
		logic [3:0] o;
		t = dig(a);
		o = dig(b);
		return 7'({t, 3'b000}) + 7'({t, 1'b0}) + 7'(o);
	endfunction

endpackage

// ===== rtl/core/stpf_cell.sv =====
module stpf_cell
	import stpf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  logic  clear,
	input  char_t din,
	output char_t dout
);

	char_t char_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= CH_NUL;
		end else if (clear) begin
			char_q <= CH_NUL;
		end else if (shift) begin
			char_q <= din;
		end
	end

	assign dout = char_q;

endmodule

// ===== rtl/core/stpf_eval.sv =====
module stpf_eval
	import stpf_pkg::*;
(
	input  snap_t   snap,
	output result_t res
);

	char_t [WINDOW_DEPTH-1:0] w;
	logic       is_1970;
	logic [6:0] hour;
	logic [6:0] minute;
	logic [6:0] second;
	logic [6:0] day;
	logic [6:0] year;
	logic [6:0] year_fat;
	logic [3:0] month;
	logic       clock_ok;
	logic       frame_ok;
	logic       day_ok;
	logic       stamp_ok;

	assign w = snap.win;

	always_comb begin
		case (w[0])
			CH_UP_A: month = (w[1] == CH_LO_P) ? 4'd4 : 4'd8;
			CH_UP_D: month = 4'd12;
			CH_UP_F: month = 4'd2;
			CH_UP_J: month = (w[1] == CH_LO_A) ? 4'd1 : ((w[2] == CH_LO_N) ? 4'd6 : 4'd7);
			CH_UP_M: month = (w[2] == CH_LO_R) ? 4'd3 : 4'd5;
			CH_UP_N: month = 4'd11;
			CH_UP_O: month = 4'd10;
			CH_UP_S: month = 4'd9;
			default: month = 4'd0;
		endcase
	end

	always_comb begin
		is_1970 = (w[MATCH_AT+8] == CH_SPACE) && (w[MATCH_AT+9] == CH_1) &&
		          (w[MATCH_AT+10] == CH_9) && (w[MATCH_AT+11] == CH_7) &&
		          (w[MATCH_AT+12] == CH_0);
		hour     = two_dig(w[MATCH_AT], w[MATCH_AT+1]);
		minute   = two_dig(w[MATCH_AT+3], w[MATCH_AT+4]);
		second   = two_dig(w[MATCH_AT+6], w[MATCH_AT+7]);
		clock_ok = snap.matched && !is_1970 && (hour < 7'(HOUR_LIM));

		frame_ok = snap.pos_ok && (w[MATCH_AT-1] == CH_SPACE) &&
		           (w[MATCH_AT-4] == CH_SPACE) && (w[MATCH_AT+8] == CH_SPACE) &&
		           (w[MATCH_AT+9] == CH_2) && (w[MATCH_AT+10] == CH_0) &&
		           is_digit(w[MATCH_AT+11]) && is_digit(w[MATCH_AT+12]);
		// day: one or two digits ending right before the space ahead of the time
		if (is_digit(w[MATCH_AT-3])) begin
			day = two_dig(w[MATCH_AT-3], w[MATCH_AT-2]);
		end else begin
			day = 7'(dig(w[MATCH_AT-2]));
		end
		day_ok = is_digit(w[MATCH_AT-2]) &&
		         (is_digit(w[MATCH_AT-3]) || (w[MATCH_AT-3] == CH_SPACE)) &&
		         (day != 7'd0) && (day <= 7'(DAY_MAX));
		year     = two_dig(w[MATCH_AT+11], w[MATCH_AT+12]);
		year_fat = year + 7'(YEAR_BIAS);
		stamp_ok = clock_ok && frame_ok && (month != 4'd0) && day_ok &&
		           (year >= 7'(YEAR_MIN)) && (year <= 7'(YEAR_MAX));
	end

	always_comb begin
		res             = '0;
		res.clock_found = clock_ok;
		if (clock_ok) begin
			res.hour   = hour[4:0];
			res.minute = minute[5:0];
			res.second = second[5:0];
		end
		res.stamp_valid = stamp_ok;
		if (stamp_ok) begin
			res.fat_date = {year_fat, month, day[4:0]};
			res.fat_time = {hour[4:0], minute[5:0], 5'b00000};
		end
	end

endmodule

// ===== rtl/core/sntp_time_text_to_fat_stamp.sv =====
// channel  | signals                          | item
// s_axis   | tvalid tready tdata[7:0] tlast   | one text character, tlast ends the text
// m_axis   | tvalid tready tdata[55:0]        | one scan result per text
//
// One character is taken per cycle while s_axis_tready is high; the row of window cells shifts once
// per nonzero character taken until the tail is held. A text ends on tlast or a zero character; its
// result goes into the snapshot register, then is decoded into the output register that drives m_axis.
// Reset clears the window, the scan counters and the valid flags of both result stages.
// s_axis stalls only while both result stages hold items that m_axis has not taken.
module sntp_time_text_to_fat_stamp
	import stpf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [7:0] character
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // clock_found, hour, minute, second,
	                                              // stamp_valid, fat_date, fat_time
);

	phase_t     phase_q, phase_d, phase_a;
	logic [4:0] pos_q, pos_d, pos_a;
	logic [2:0] tail_q, tail_d, tail_a;

	char_t [WINDOW_DEPTH-1:0] win;
	char_t [WINDOW_DEPTH-1:0] wa;
	char_t [WINDOW_DEPTH-1:0] pad;

	logic    acc, nz, ends, shift_en, hit;
	logic [2:0] pad_k;
	snap_t   snap, snap_s1;
	logic    valid_s1, valid_s2;
	result_t res, res_s2;
	logic    out_free;

	assign acc  = s_axis_tvalid && s_axis_tready;
	assign nz   = (s_axis_tdata != CH_NUL);
	assign ends = acc && (!nz || s_axis_tlast);

	assign hit = in_range(win[13], CH_0, CH_2) && is_digit(win[14]) &&
	             (win[15] == CH_COLON) && in_range(win[16], CH_0, CH_5) &&
	             is_digit(win[17]) && (win[18] == CH_COLON) &&
	             in_range(win[19], CH_0, CH_5) && is_digit(s_axis_tdata);

	// next state
	always_comb begin
		phase_a = phase_q;
		pos_a   = pos_q;
		tail_a  = tail_q;
		if (acc && nz) begin
			case (phase_q)
				PH_SCAN: begin
					if (pos_q != 5'(POS_SAT)) pos_a = pos_q + 5'd1;
					if (hit) begin
						phase_a = PH_TAIL;
						tail_a  = 3'd0;
					end
				end
				PH_TAIL: begin
					tail_a = tail_q + 3'd1;
					if (tail_a >= 3'(TAIL_LEN)) phase_a = PH_HELD;
				end
				default: ;
			endcase
		end
		if (ends) begin
			phase_d = PH_SCAN;
			pos_d   = 5'd0;
			tail_d  = 3'd0;
		end else begin
			phase_d = phase_a;
			pos_d   = pos_a;
			tail_d  = tail_a;
		end
	end

	// outputs: window shift, end-of-text padding, snapshot
	always_comb begin
		int idx;
		shift_en = acc && nz && (phase_q != PH_HELD);
		for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
			wa[i] = shift_en ? win[i+1] : win[i];
		end
		wa[WINDOW_DEPTH-1] = shift_en ? s_axis_tdata : win[WINDOW_DEPTH-1];
		pad_k = (phase_a == PH_TAIL) ? 3'(TAIL_LEN) - tail_a : 3'd0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			idx    = i + int'(pad_k);
			pad[i] = CH_NUL;
			if (idx < WINDOW_DEPTH) pad[i] = wa[idx];
		end
		snap.win     = pad;
		snap.matched = (phase_a != PH_SCAN);
		snap.pos_ok  = (pos_a >= 5'(STAMP_MIN_POS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			pos_q   <= 5'd0;
			tail_q  <= 3'd0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			tail_q  <= tail_d;
		end
	end

	for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
		char_t din;
		if (g == WINDOW_DEPTH - 1) begin : g_head
			assign din = s_axis_tdata;
		end else begin : g_body
			assign din = win[g+1];
		end
		stpf_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift_en),
			.clear (ends),
			.din   (din),
			.dout  (win[g])
		);
	end

	stpf_eval u_eval (
		.snap(snap_s1),
		.res (res)
	);

	assign out_free      = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ends) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ends) snap_s1 <= snap;
		if (out_free && valid_s1) res_s2 <= res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_TDATA_W'(res_s2);

endmodule

// ===== rtl/core/stpf_checker.sv =====
module stpf_checker
	import stpf_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic        found, stamp;
	logic [4:0]  hour;
	logic [5:0]  minute, second;
	logic [15:0] fat_time;

	assign found    = m_axis_tdata[0];
	assign hour     = m_axis_tdata[5:1];
	assign minute   = m_axis_tdata[11:6];
	assign second   = m_axis_tdata[17:12];
	assign stamp    = m_axis_tdata[18];
	assign fat_time = m_axis_tdata[50:35];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed under stall");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !found |-> hour == 5'd0 && minute == 6'd0 && second == 6'd0 &&
		!stamp)
		else $error("fields set without a clock match");

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && found |-> hour < 5'(HOUR_LIM) && minute < 6'd60 && second < 6'd60)
		else $error("time out of range");

	a_stamp_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && stamp |-> fat_time[15:11] == hour && fat_time[10:5] == minute &&
		fat_time[4:0] == 5'd0)
		else $error("stamp time disagrees with clock fields");

	a_stamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !stamp |-> m_axis_tdata[50:19] == 32'd0)
		else $error("stamp fields set without a valid stamp");

endmodule

bind sntp_time_text_to_fat_stamp stpf_checker u_stpf_checker (.*);

// ===== dv/tb_sntp_time_text_to_fat_stamp.sv =====
module tb_sntp_time_text_to_fat_stamp
	import stpf_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 60;
	localparam int PHASE_TEXTS = 3;
	localparam int N_DIR       = 18;

	typedef enum int {
		END_LAST,
		END_NUL,
		END_NUL_LAST
	} text_end_e;

	typedef struct packed {
		logic    typed;
		result_t res;
	} verdict_note_t;

	localparam result_t R_NONE = '0;
	localparam result_t R_LATE = '{fat_time: 16'((23 << 11) | (59 << 5)),
		fat_date: 16'((71 << 9) | (12 << 5) | 31), stamp_valid: 1'b1,
		second: 6'd59, minute: 6'd59, hour: 5'd23, clock_found: 1'b1};
	localparam result_t R_BARE = '{clock_found: 1'b1, hour: 5'd12, minute: 6'd34,
		second: 6'd56, default: '0};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata;  // [7:0] character
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // clock_found, hour, minute, second,
	                                       // stamp_valid, fat_date, fat_time

	sntp_time_text_to_fat_stamp DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #6 clk = ~clk;

	string dir_txt [N_DIR] = '{
		"",
		"",
		"Thu Jan  1 00:00:00 1970",
		"Sun Dec 31 23:59:59 2051",
		"Fri Feb  9 24:00:00 2030",
		"12:34:56",
		"29:60:59 3",
		"Sat Jun  1 00:00:00 2020",
		"Wed Jul 04 01:02:03 2019",
		"Mon Mar 15 10:20:30 2052",
		"Tue May 32 10:20:30 2030",
		"Thu Aug 00 10:20:30 2030",
		"Fri Apr x5 10:20:30 2030",
		"Sat Sep  7 20:21:22 2025\377\001",
		"Sun Oct 17 11:22:33 2031 01:02:03",
		"Nov  7 20:21:22 2025",
		"Mon Zzz 12 01:01:01 2030",
		"\377\001 Jan  9 09:08:07 20"
	};
	text_end_e dir_end [N_DIR] = '{
		END_NUL, END_NUL_LAST, END_LAST, END_LAST, END_LAST, END_LAST, END_NUL,
		END_LAST, END_LAST, END_LAST, END_LAST, END_LAST, END_LAST, END_LAST,
		END_NUL_LAST, END_LAST, END_LAST, END_LAST
	};
	bit dir_typed [N_DIR] = '{1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	result_t dir_exp [N_DIR] = '{
		R_NONE, R_NONE, R_NONE, R_LATE, R_NONE, R_BARE, R_NONE,
		R_NONE, R_NONE, R_NONE, R_NONE, R_NONE, R_NONE, R_NONE,
		R_NONE, R_NONE, R_NONE, R_NONE
	};

	string mon_names [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
		"Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
	string day_names [7] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
	int send_idle_by_phase [4] = '{0, 48, 0, 31};
	int stall_by_phase [4] = '{0, 0, 48, 31};

	// scanner model state
	char_t      scan_win [WINDOW_DEPTH];
	logic [4:0] scan_pos;
	phase_t     scan_ph;
	logic [2:0] scan_tail;

	result_t       stamps_due [$];
	verdict_note_t typed_verdicts [$];
	char_t         line_q [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int quiet_cycles = 0;
	int n_sent = 0;
	int n_texts = 0;
	int n_results = 0;
	int n_found = 0;
	int n_stamps = 0;
	int n_errors = 0;

	function automatic void scan_clear();
		int i;
		for (i = 0; i < WINDOW_DEPTH; i++)
			scan_win[i] = CH_NUL;
		scan_pos = '0;
		scan_ph = PH_SCAN;
		scan_tail = '0;
	endfunction

	function automatic void win_push(char_t c);
		int i;
		for (i = 0; i < WINDOW_DEPTH - 1; i++)
			scan_win[i] = scan_win[i + 1];
		scan_win[WINDOW_DEPTH - 1] = c;
	endfunction

	function automatic bit is_num(char_t c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic int num2(char_t a, char_t b);
		return (int'(a) - int'(CH_0)) * 10 + (int'(b) - int'(CH_0));
	endfunction

	function automatic bit clock_at(int p);
		return scan_win[p] >= CH_0 && scan_win[p] <= CH_2 && is_num(scan_win[p + 1]) &&
			scan_win[p + 2] == CH_COLON && scan_win[p + 3] >= CH_0 &&
			scan_win[p + 3] <= CH_5 && is_num(scan_win[p + 4]) &&
			scan_win[p + 5] == CH_COLON && scan_win[p + 6] >= CH_0 &&
			scan_win[p + 6] <= CH_5 && is_num(scan_win[p + 7]);
	endfunction

	function automatic int month_of(char_t m0, char_t m1, char_t m2);
		case (m0)
		CH_UP_A: return (m1 == CH_LO_P) ? 4 : 8;
		CH_UP_D: return 12;
		CH_UP_F: return 2;
		CH_UP_J: return (m1 == CH_LO_A) ? 1 : ((m2 == CH_LO_N) ? 6 : 7);
		CH_UP_M: return (m2 == CH_LO_R) ? 3 : 5;
		CH_UP_N: return 11;
		CH_UP_O: return 10;
		CH_UP_S: return 9;
		default: return 0;
		endcase
	endfunction

	// match sits at window cells 7..14, date before it, year after it
	function automatic result_t scan_verdict();
		result_t r;
		int hh, mm, ss, mon, dd, yy;
		r = '0;
		if (scan_ph == PH_SCAN)
			return r;
		if (scan_win[15] == CH_SPACE && scan_win[16] == CH_1 && scan_win[17] == CH_9 &&
				scan_win[18] == CH_7 && scan_win[19] == CH_0)
			return r;
		hh = num2(scan_win[7], scan_win[8]);
		mm = num2(scan_win[10], scan_win[11]);
		ss = num2(scan_win[13], scan_win[14]);
		if (hh >= HOUR_LIM)
			return r;
		r.clock_found = 1'b1;
		r.hour = 5'(hh);
		r.minute = 6'(mm);
		r.second = 6'(ss);
		if (scan_pos < STAMP_MIN_POS || scan_win[6] != CH_SPACE || scan_win[3] != CH_SPACE ||
				scan_win[15] != CH_SPACE || scan_win[16] != CH_2 || scan_win[17] != CH_0 ||
				!is_num(scan_win[18]) || !is_num(scan_win[19]))
			return r;
		mon = month_of(scan_win[0], scan_win[1], scan_win[2]);
		if (mon == 0 || !is_num(scan_win[5]))
			return r;
		dd = int'(scan_win[5]) - int'(CH_0);
		if (is_num(scan_win[4]))
			dd = (int'(scan_win[4]) - int'(CH_0)) * 10 + dd;
		else if (scan_win[4] != CH_SPACE)
			return r;
		yy = num2(scan_win[18], scan_win[19]);
		if (yy < YEAR_MIN || yy > YEAR_MAX || dd == 0 || dd > DAY_MAX)
			return r;
		r.stamp_valid = 1'b1;
		r.fat_date = 16'(((yy + YEAR_BIAS) << 9) | (mon << 5) | dd);
		r.fat_time = 16'((hh << 11) | (mm << 5));
		return r;
	endfunction

	function automatic bit scan_step(char_t c, logic l, output result_t r);
		r = '0;
		if (c != CH_NUL) begin
			if (scan_ph == PH_SCAN) begin
				win_push(c);
				if (scan_pos < POS_SAT)
					scan_pos++;
				if (clock_at(WINDOW_DEPTH - 8)) begin
					scan_ph = PH_TAIL;
					scan_tail = '0;
				end
			end else if (scan_ph == PH_TAIL) begin
				win_push(c);
				scan_tail++;
				if (scan_tail >= TAIL_LEN)
					scan_ph = PH_HELD;
			end
			if (!l)
				return 1'b0;
		end
		if (scan_ph == PH_TAIL) begin
			while (scan_tail < TAIL_LEN) begin
				win_push(CH_NUL);
				scan_tail++;
			end
			scan_ph = PH_HELD;
		end
		r = scan_verdict();
		scan_clear();
		return 1'b1;
	endfunction

	initial scan_clear();

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t pred, want, got;
		verdict_note_t note;
		if (s_axis_tvalid && s_axis_tready) begin
			if (scan_step(s_axis_tdata, s_axis_tlast, pred)) begin
				if (typed_verdicts.size() != 0) begin
					note = typed_verdicts.pop_front();
					stamps_due.push_back(note.typed ? note.res : pred);
				end else begin
					stamps_due.push_back(pred);
				end
			end
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[RES_W-1:0]);
			n_results++;
			if (got.clock_found === 1'b1)
				n_found++;
			if (got.stamp_valid === 1'b1)
				n_stamps++;
			if (stamps_due.size() == 0) begin
				$display("%0t: result with nothing expected, expected none actual %h",
					$time, got);
				n_errors++;
			end else begin
				want = stamps_due.pop_front();
				check_field("clock_found", 16'(want.clock_found), 16'(got.clock_found));
				check_field("hour", 16'(want.hour), 16'(got.hour));
				check_field("minute", 16'(want.minute), 16'(got.minute));
				check_field("second", 16'(want.second), 16'(got.second));
				check_field("stamp_valid", 16'(want.stamp_valid), 16'(got.stamp_valid));
				check_field("fat_date", want.fat_date, got.fat_date);
				check_field("fat_time", want.fat_time, got.fat_time);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic char_t any_char();
		case ($urandom_range(5))
		0: return char_t'($urandom_range(255));
		1: return CH_SPACE;
		2: return CH_COLON;
		3: return char_t'($urandom_range(CH_0, CH_9));
		default: return char_t'($urandom_range(32, 126));
		endcase
	endfunction

	function automatic char_t dchar(int v);
		return char_t'(int'(CH_0) + v);
	endfunction

	task automatic push_str(input string s);
		int k;
		for (k = 0; k < s.len(); k++)
			line_q.push_back(s[k]);
	endtask

	task automatic push_clock();
		int k;
		line_q.push_back(dchar(($urandom_range(15) == 0) ? 3 : $urandom_range(2)));
		line_q.push_back(dchar($urandom_range(9)));
		for (k = 0; k < 2; k++) begin
			line_q.push_back(CH_COLON);
			line_q.push_back(dchar(($urandom_range(11) == 0) ? 6 : $urandom_range(5)));
			line_q.push_back(dchar($urandom_range(9)));
		end
	endtask

	task automatic make_line();
		int kind, n, k;
		line_q.delete();
		kind = $urandom_range(9);
		if (kind < 6) begin
			n = ($urandom_range(3) == 0) ? $urandom_range(1, 14) : 0;
			repeat (n) line_q.push_back(any_char());
			push_str(day_names[$urandom_range(6)]);
			line_q.push_back(CH_SPACE);
			if ($urandom_range(9) == 0) begin
				line_q.push_back(char_t'($urandom_range(65, 90)));
				line_q.push_back(char_t'($urandom_range(97, 122)));
				line_q.push_back(char_t'($urandom_range(97, 122)));
			end else begin
				push_str(mon_names[$urandom_range(11)]);
			end
			line_q.push_back(CH_SPACE);
			case ($urandom_range(7))
			0: line_q.push_back(any_char());
			1, 2, 3: line_q.push_back(CH_SPACE);
			default: line_q.push_back(dchar($urandom_range(3)));
			endcase
			line_q.push_back(dchar($urandom_range(9)));
			line_q.push_back(CH_SPACE);
			push_clock();
			line_q.push_back(($urandom_range(11) == 0) ? any_char() : CH_SPACE);
			case ($urandom_range(5))
			0: push_str("1970");
			1: repeat (4) line_q.push_back(dchar($urandom_range(9)));
			default: begin
				push_str("20");
				line_q.push_back(dchar($urandom_range(1, 5)));
				line_q.push_back(dchar($urandom_range(9)));
			end
			endcase
			if ($urandom_range(3) == 0)
				line_q[$urandom_range(line_q.size() - 1)] = any_char();
			if ($urandom_range(4) == 0) begin
				n = $urandom_range(1, line_q.size());
				while (line_q.size() > n)
					void'(line_q.pop_back());
			end
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 6)) line_q.push_back(any_char());
		end else if (kind < 8) begin
			push_clock();
			repeat ($urandom_range(6)) line_q.push_back(any_char());
		end else begin
			n = $urandom_range(1, 30);
			for (k = 0; k < n; k++)
				line_q.push_back(any_char());
		end
		if ($urandom_range(29) == 0)
			line_q.delete();
	endtask

	task automatic send_item(input char_t c, input logic l, input logic typed,
			input result_t res);
		verdict_note_t note;
		if (c == CH_NUL || l) begin
			note.typed = typed;
			note.res = res;
			typed_verdicts.push_back(note);
		end
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= l;
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
	endtask

	task automatic send_line(input text_end_e how, input logic typed, input result_t res);
		int k;
		if (line_q.size() == 0 && how == END_LAST)
			how = END_NUL;
		for (k = 0; k < line_q.size(); k++)
			send_item(line_q[k], how == END_LAST && k == line_q.size() - 1, typed, res);
		if (how != END_LAST)
			send_item(CH_NUL, how == END_NUL_LAST, typed, res);
		n_texts++;
	endtask

	initial begin
		int i, k, ph, sent0, texts0;
		bit held;
		text_end_e how;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIR; i++) begin
			line_q.delete();
			for (k = 0; k < dir_txt[i].len(); k++)
				line_q.push_back(dir_txt[i][k]);
			send_line(dir_end[i], dir_typed[i], dir_exp[i]);
		end

		held = 1'b0;
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			if (ph == 2) begin
				// drain everything before going on
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (stamps_due.size() != 0)
					@(posedge clk);
			end
			sent0 = n_sent;
			texts0 = n_texts;
			while (n_sent - sent0 < PHASE_ITEMS || n_texts - texts0 < PHASE_TEXTS) begin
				if (ph == 0 && !held && n_sent - sent0 >= 20) begin
					hold_req = 150;
					held = 1'b1;
				end
				make_line();
				case ($urandom_range(9))
				0: how = END_NUL;
				1: how = END_NUL_LAST;
				default: how = END_LAST;
				endcase
				send_line(how, 1'b0, R_NONE);
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (stamps_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d characters in %0d texts, %0d results", n_sent, n_texts, n_results);
		$display("%0d with a time of day, %0d with a FAT stamp, %0d mismatches",
			n_found, n_stamps, n_errors);
		if (n_errors == 0 && stamps_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/stpf_pkg.sv
rtl/core/stpf_cell.sv
rtl/core/stpf_eval.sv
rtl/core/sntp_time_text_to_fat_stamp.sv
rtl/core/stpf_checker.sv
dv/tb_sntp_time_text_to_fat_stamp.sv
